// ===== rtl/core/spq_pkg.sv =====
// Package for the stable priority queue: codes, payload types, defaults.
package spq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int PRIO_BITS = 8;
    localparam int ID_BITS   = 16;

    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t                 cmd;
        logic [PRIO_BITS-1:0] priority_req;
        logic [ID_BITS-1:0]   job_id;
    } req_t;

    typedef struct packed {
        status_t              status;
        logic [PRIO_BITS-1:0] out_priority;
        logic [ID_BITS-1:0]   out_job_id;
        logic                 now_empty;
    } rsp_t;

    // One stored entry.
    typedef struct packed {
        logic [PRIO_BITS-1:0] prio;
        logic [ID_BITS-1:0]   id;
    } entry_t;

    // Per-cycle operation broadcast to every cell.
    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t ins;
    } cell_op_t;

endpackage

// ===== rtl/core/stable_priority_queue.sv =====
// Top level of the stable priority queue: a sorted row of cells.
//
//  channel   | ports                 | handshake
//  ----------+-----------------------+---------------------------------------
//  command   | start, busy, request  | transaction taken when start && !busy
//  result    | done, result          | one-cycle strobe, cannot be held off
//
// Every command is handled without waiting: the cell row inserts or shifts
// in the accept cycle and the result appears on the next cycle with done.
// busy stays low, so a new transaction may be issued every cycle.
// Reset clears the entry count and the result strobe; cell contents are
// not reset and are only read below the count.
// The receiver cannot stall: a result is present for exactly one cycle.
module stable_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  spq_pkg::req_t request,
    output logic          done,
    output spq_pkg::rsp_t result
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    logic             done_next;
    spq_pkg::rsp_t    result_reg;
    spq_pkg::rsp_t    result_next;

    logic              accept;
    logic              full;
    logic              empty;
    spq_pkg::cell_op_t op;

    // Chain wiring, one entry per cell; both ends are tied off in the loop.
    logic            gt   [DEPTH];
    spq_pkg::entry_t data [DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);

    // Operation broadcast; refused commands leave the row untouched.
    always_comb
    begin
        op.enq      = accept && (request.cmd == spq_pkg::CMD_ENQ) && !full;
        op.deq      = accept && (request.cmd == spq_pkg::CMD_DEQ) && !empty;
        op.ins.prio = request.priority_req;
        op.ins.id   = request.job_id;
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic            c_valid;
            logic            c_left_gt;
            spq_pkg::entry_t c_left;
            spq_pkg::entry_t c_right;

            assign c_valid = (count_reg > CNT_W'(i));

            if (i == 0)
            begin : g_head
                assign c_left_gt = 1'b0;
                assign c_left    = '0;
            end
            else
            begin : g_mid
                assign c_left_gt = gt[i-1];
                assign c_left    = data[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign c_right = '0;
            end
            else
            begin : g_body
                assign c_right = data[i+1];
            end

            spq_cell u_cell (
                .clk        (clk),
                .op         (op),
                .valid      (c_valid),
                .left_gt    (c_left_gt),
                .left_data  (c_left),
                .right_data (c_right),
                .gt         (gt[i]),
                .data       (data[i])
            );
        end
    endgenerate

    // Count and result for the accepted transaction.
    always_comb
    begin
        count_next  = count_reg;
        done_next   = accept;
        result_next = result_reg;
        if (accept)
        begin
            result_next.out_priority = '0;
            result_next.out_job_id   = '0;
            case (request.cmd)
                spq_pkg::CMD_ENQ:
                begin
                    if (full)
                    begin
                        result_next.status = spq_pkg::ST_FULL;
                    end
                    else
                    begin
                        result_next.status = spq_pkg::ST_OK;
                        count_next         = count_reg + CNT_W'(1);
                    end
                end
                spq_pkg::CMD_DEQ:
                begin
                    if (empty)
                    begin
                        result_next.status = spq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        // Head cell holds the lowest, oldest entry.
                        result_next.status       = spq_pkg::ST_OK;
                        result_next.out_priority = data[0].prio;
                        result_next.out_job_id   = data[0].id;
                        count_next               = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    result_next.status = spq_pkg::ST_OK;
                end
            endcase
            result_next.now_empty = (count_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/core/spq_cell.sv =====
// One queue cell: holds an entry, inserts or shifts with its neighbors.
module spq_cell (
    input  logic              clk,
    input  spq_pkg::cell_op_t op,
    input  logic              valid,
    input  logic              left_gt,
    input  spq_pkg::entry_t   left_data,
    input  spq_pkg::entry_t   right_data,
    output logic              gt,
    output spq_pkg::entry_t   data
);

    spq_pkg::entry_t data_reg;
    spq_pkg::entry_t data_next;

    // Empty cells and cells holding a strictly larger priority give way,
    // so an equal priority lands behind the stored ones.
    assign gt   = !valid || (data_reg.prio > op.ins.prio);
    assign data = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (op.enq && gt)
        begin
            data_next = left_gt ? left_data : op.ins;
        end
        else if (op.deq)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule
